// ===== src/bmp_pixel_stream_decoder_core_defines.svh =====
// assertion macros used by the checker file
`ifndef BMP_PIXEL_STREAM_DECODER_CORE_DEFINES_SVH
`define BMP_PIXEL_STREAM_DECODER_CORE_DEFINES_SVH

// property checked while reset is low
`define BMPD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define BMPD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bmpd_pkg.sv =====
// package with codes and constants of the bmp pixel stream decoder
package bmpd_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int MAX_HEIGHT   = 4096;
  localparam int PALETTE_SIZE = 256;

  localparam int CFG_W   = 13;
  localparam int CURX_W  = 13;
  localparam int ROW_W   = 14;
  localparam int COORD_W = 12;
  localparam int BYTE_W  = 8;
  localparam int RGB_W   = 24;
  localparam int PAL_AW  = $clog2(PALETTE_SIZE);

  // request types
  localparam logic [1:0] REQ_START   = 2'd0;
  localparam logic [1:0] REQ_PALETTE = 2'd1;
  localparam logic [1:0] REQ_DATA    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_TOP_DOWN = 2'd2;
  localparam logic [1:0] CFG_MODE     = 2'd3;

  // pixel modes
  localparam logic [1:0] MODE_INDEXED = 2'd0;
  localparam logic [1:0] MODE_RLE8    = 2'd1;
  localparam logic [1:0] MODE_BGR24   = 2'd2;

  // result kinds
  localparam logic KIND_SPAN = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // rle8 escape codes after a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [CURX_W-1:0] CURSOR_X_MAX = '1;

  typedef enum logic [2:0] {
    PH_COUNT   = 3'd0,
    PH_SECOND  = 3'd1,
    PH_DELTA_X = 3'd2,
    PH_DELTA_Y = 3'd3,
    PH_ABS     = 3'd4,
    PH_ABS_PAD = 3'd5
  } phase_t;

endpackage

// ===== src/bmp_pixel_stream_decoder_core.sv =====
// bmp pixel data decoder: indexed, rle8 and 24-bit streams to rgb pixel spans
//
//   channel   handshake              payload
//   input     in_valid / in_ready    req_type palette_index pal_red pal_green pal_blue data_byte
//   output    out_valid / out_ready  kind pos_x pos_y span_length red green blue
//   config    cfg_we                 cfg_index cfg_data
//
// one transaction per cycle while in_ready is high; its result passes through
// the registered palette read stage and then the output register.
// reset is synchronous and clears control state and configuration; the palette
// keeps its contents. a stalled output keeps in_ready high while the middle
// stage is free, so one more transaction is taken behind a waiting result.
module bmp_pixel_stream_decoder_core
  import bmpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         req_type,
  input  logic [7:0]         palette_index,
  input  logic [7:0]         pal_red,
  input  logic [7:0]         pal_green,
  input  logic [7:0]         pal_blue,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [COORD_W-1:0] pos_x,
  output logic [COORD_W-1:0] pos_y,
  output logic [7:0]         span_length,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue
);

  localparam logic [1:0] CMP_BLUE  = 2'd0;
  localparam logic [1:0] CMP_GREEN = 2'd1;
  localparam logic [1:0] CMP_RED   = 2'd2;

  // configuration
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic             top_down;
  logic [1:0]       pixel_mode;

  // decode state
  logic [CURX_W-1:0] cursor_x, cursor_x_next;
  logic [ROW_W-1:0]  cursor_row, cursor_row_next;
  phase_t            decode_phase, decode_phase_next;
  logic [7:0]        run_remaining, run_remaining_next;
  logic [7:0]        held_count, held_count_next;
  logic [7:0]        held_delta_x, held_delta_x_next;
  logic [1:0]        component_phase, component_phase_next;
  logic [15:0]       partial_color, partial_color_next;
  logic [1:0]        pad_remaining, pad_remaining_next;
  logic              pad_after_run, pad_after_run_next;
  logic              finished, finished_next;

  // palette
  logic [RGB_W-1:0] palette_mem [PALETTE_SIZE];
  logic [RGB_W-1:0] pal_rdata;

  // middle stage
  logic               s1_valid;
  logic               s1_kind;
  logic [COORD_W-1:0] s1_x;
  logic [COORD_W-1:0] s1_y;
  logic [7:0]         s1_len;
  logic [RGB_W-1:0]   s1_rgb;
  logic               s1_use_pal;
  logic               s1_move;
  logic               in_fire;

  // decode results
  logic               res_valid;
  logic               res_kind;
  logic [COORD_W-1:0] res_x;
  logic [7:0]         res_len;
  logic [RGB_W-1:0]   res_rgb;
  logic               res_use_pal;

  logic [CFG_W-1:0]   w_eff;
  logic [CFG_W-1:0]   h_eff;
  logic [ROW_W-1:0]   dest_full;
  logic [COORD_W-1:0] dest_row;
  logic               x_in_image;
  logic [CFG_W-1:0]   room;
  logic [7:0]         span_n;
  logic [ROW_W-1:0]   row_plus_b;
  logic [CURX_W:0]    x_plus_dx;
  logic [CURX_W:0]    x_plus_one;
  logic               do_raw;
  logic [1:0]         raw_pad;
  logic [RGB_W-1:0]   raw_rgb;
  logic               raw_use_pal;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CFG_W'(1);
    end else if (image_width > CFG_W'(MAX_WIDTH)) begin
      w_eff = CFG_W'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = CFG_W'(1);
    end else if (image_height > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  assign dest_full  = ROW_W'(h_eff) - ROW_W'(1) - cursor_row;
  assign dest_row   = top_down ? cursor_row[COORD_W-1:0] : dest_full[COORD_W-1:0];
  assign x_in_image = cursor_x < w_eff;
  assign room       = w_eff - cursor_x;
  assign span_n     = (CFG_W'(held_count) < room) ? held_count : room[7:0];
  assign row_plus_b = cursor_row + ROW_W'(data_byte);
  assign x_plus_dx  = (CURX_W+1)'(cursor_x) + (CURX_W+1)'(held_delta_x);
  assign x_plus_one = (CURX_W+1)'(cursor_x) + (CURX_W+1)'(1);

  always_comb begin
    cursor_x_next        = cursor_x;
    cursor_row_next      = cursor_row;
    decode_phase_next    = decode_phase;
    run_remaining_next   = run_remaining;
    held_count_next      = held_count;
    held_delta_x_next    = held_delta_x;
    component_phase_next = component_phase;
    partial_color_next   = partial_color;
    pad_remaining_next   = pad_remaining;
    pad_after_run_next   = pad_after_run;
    finished_next        = finished;
    res_valid            = 1'b0;
    res_kind             = KIND_SPAN;
    res_x                = cursor_x[COORD_W-1:0];
    res_len              = 8'd1;
    res_rgb              = '0;
    res_use_pal          = 1'b1;
    do_raw               = 1'b0;
    raw_pad              = '0;
    raw_rgb              = '0;
    raw_use_pal          = 1'b1;

    if (in_fire) begin
      unique case (req_type)
        REQ_START: begin
          cursor_x_next        = '0;
          cursor_row_next      = '0;
          decode_phase_next    = PH_COUNT;
          run_remaining_next   = '0;
          held_count_next      = '0;
          held_delta_x_next    = '0;
          component_phase_next = '0;
          partial_color_next   = '0;
          pad_remaining_next   = '0;
          pad_after_run_next   = 1'b0;
          finished_next        = 1'b0;
        end
        REQ_DATA: begin
          if (!finished && (pixel_mode == MODE_INDEXED || pixel_mode == MODE_RLE8 ||
                            pixel_mode == MODE_BGR24)) begin
            if (cursor_row >= ROW_W'(h_eff)) begin
              // rows shrunk under the cursor
              finished_next = 1'b1;
            end else if (pixel_mode == MODE_RLE8) begin
              unique case (decode_phase)
                PH_SECOND: begin
                  decode_phase_next = PH_COUNT;
                  if (held_count != '0) begin
                    // encoded run clipped to the row
                    if (x_in_image) begin
                      res_valid     = 1'b1;
                      res_len       = span_n;
                      cursor_x_next = cursor_x + CURX_W'(span_n);
                    end
                  end else if (data_byte == ESC_EOL) begin
                    cursor_x_next   = '0;
                    cursor_row_next = cursor_row + ROW_W'(1);
                    if (cursor_row + ROW_W'(1) >= ROW_W'(h_eff)) begin
                      finished_next = 1'b1;
                      res_valid     = 1'b1;
                      res_kind      = KIND_END;
                    end
                  end else if (data_byte == ESC_EOB) begin
                    finished_next = 1'b1;
                    res_valid     = 1'b1;
                    res_kind      = KIND_END;
                  end else if (data_byte == ESC_DELTA) begin
                    decode_phase_next = PH_DELTA_X;
                  end else begin
                    run_remaining_next = data_byte;
                    pad_after_run_next = data_byte[0];
                    decode_phase_next  = PH_ABS;
                  end
                end
                PH_DELTA_X: begin
                  held_delta_x_next = data_byte;
                  decode_phase_next = PH_DELTA_Y;
                end
                PH_DELTA_Y: begin
                  decode_phase_next = PH_COUNT;
                  cursor_x_next     = x_plus_dx[CURX_W] ? CURSOR_X_MAX
                                                        : x_plus_dx[CURX_W-1:0];
                  cursor_row_next   = row_plus_b;
                  if (row_plus_b >= ROW_W'(h_eff)) begin
                    finished_next = 1'b1;
                    res_valid     = 1'b1;
                    res_kind      = KIND_END;
                  end
                end
                PH_ABS: begin
                  res_valid     = x_in_image;
                  cursor_x_next = x_plus_one[CURX_W] ? CURSOR_X_MAX
                                                     : x_plus_one[CURX_W-1:0];
                  if (run_remaining <= 8'd1) begin
                    run_remaining_next = '0;
                    decode_phase_next  = pad_after_run ? PH_ABS_PAD : PH_COUNT;
                  end else begin
                    run_remaining_next = run_remaining - 8'd1;
                  end
                end
                PH_ABS_PAD: begin
                  decode_phase_next = PH_COUNT;
                end
                default: begin
                  held_count_next   = data_byte;
                  decode_phase_next = PH_SECOND;
                end
              endcase
            end else if (pad_remaining != '0) begin
              pad_remaining_next = pad_remaining - 2'd1;
            end else if (pixel_mode == MODE_INDEXED) begin
              do_raw  = 1'b1;
              raw_pad = 2'(3'd4 - {1'b0, w_eff[1:0]});
            end else begin
              priority if (component_phase == CMP_BLUE) begin
                partial_color_next   = {partial_color[15:8], data_byte};
                component_phase_next = CMP_GREEN;
              end else if (component_phase == CMP_GREEN) begin
                partial_color_next   = {data_byte, partial_color[7:0]};
                component_phase_next = CMP_RED;
              end else begin
                component_phase_next = CMP_BLUE;
                do_raw      = 1'b1;
                raw_pad     = w_eff[1:0];
                raw_rgb     = {data_byte, partial_color};
                raw_use_pal = 1'b0;
              end
            end

            // one pixel of an uncompressed row, with a row advance at the end of the row
            if (do_raw) begin
              res_valid   = x_in_image;
              res_rgb     = raw_rgb;
              res_use_pal = raw_use_pal;
              if (x_plus_one >= (CURX_W+1)'(w_eff)) begin
                cursor_x_next      = '0;
                cursor_row_next    = cursor_row + ROW_W'(1);
                pad_remaining_next = raw_pad;
                if (cursor_row + ROW_W'(1) >= ROW_W'(h_eff)) begin
                  finished_next = 1'b1;
                end
              end else begin
                cursor_x_next = x_plus_one[CURX_W-1:0];
              end
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (res_kind == KIND_END) begin
      res_x       = '0;
      res_len     = '0;
      res_rgb     = '0;
      res_use_pal = 1'b0;
    end
  end

  // palette storage, read port registered
  always_ff @(posedge clk) begin
    if (in_fire && req_type == REQ_PALETTE) begin
      palette_mem[palette_index] <= {pal_red, pal_green, pal_blue};
    end
    if (in_fire && req_type == REQ_DATA) begin
      pal_rdata <= palette_mem[data_byte];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= CFG_W'(1);
      image_height    <= CFG_W'(1);
      top_down        <= 1'b0;
      pixel_mode      <= MODE_INDEXED;
      cursor_x        <= '0;
      cursor_row      <= '0;
      decode_phase    <= PH_COUNT;
      run_remaining   <= '0;
      held_count      <= '0;
      held_delta_x    <= '0;
      component_phase <= '0;
      partial_color   <= '0;
      pad_remaining   <= '0;
      pad_after_run   <= 1'b0;
      finished        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WIDTH:    image_width  <= cfg_data;
          CFG_HEIGHT:   image_height <= cfg_data;
          CFG_TOP_DOWN: top_down     <= cfg_data[0];
          CFG_MODE:     pixel_mode   <= cfg_data[1:0];
        endcase
      end
      cursor_x        <= cursor_x_next;
      cursor_row      <= cursor_row_next;
      decode_phase    <= decode_phase_next;
      run_remaining   <= run_remaining_next;
      held_count      <= held_count_next;
      held_delta_x    <= held_delta_x_next;
      component_phase <= component_phase_next;
      partial_color   <= partial_color_next;
      pad_remaining   <= pad_remaining_next;
      pad_after_run   <= pad_after_run_next;
      finished        <= finished_next;
    end
  end

  // middle stage waits for the palette data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= res_valid;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (in_fire) begin
      s1_kind    <= res_kind;
      s1_x       <= res_x;
      s1_y       <= (res_kind == KIND_END) ? '0 : dest_row;
      s1_len     <= res_len;
      s1_rgb     <= res_rgb;
      s1_use_pal <= res_use_pal;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_move) begin
      kind        <= s1_kind;
      pos_x       <= s1_x;
      pos_y       <= s1_y;
      span_length <= s1_len;
      {red, green, blue} <= s1_use_pal ? pal_rdata : s1_rgb;
    end
  end

endmodule

// ===== src/bmpd_checker.sv =====
// port checker of the bmp pixel stream decoder, bound to the top level
`include "bmp_pixel_stream_decoder_core_defines.svh"

module bmpd_checker
  import bmpd_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               kind,
  input logic [COORD_W-1:0] pos_x,
  input logic [COORD_W-1:0] pos_y,
  input logic [7:0]         span_length,
  input logic [7:0]         red,
  input logic [7:0]         green,
  input logic [7:0]         blue
);

  logic end_seen;
  logic end_zero;
  logic span_seen;
  logic out_wait;
  logic in_seen;

  assign end_seen  = out_valid && (kind == KIND_END);
  assign end_zero  = (pos_x == '0) && (pos_y == '0) && (span_length == '0) &&
                     (red == '0) && (green == '0) && (blue == '0);
  assign span_seen = out_valid && (kind == KIND_SPAN);
  assign out_wait  = out_valid && !out_ready;
  assign in_seen   = in_valid && in_ready;

  // end of image carries an all-zero payload
  `BMPD_ASSERT(a_end_zero, clk, rst, end_seen |-> end_zero, "end of image with nonzero payload")

  // spans are never empty
  `BMPD_ASSERT(a_span_len, clk, rst, span_seen |-> span_length != '0, "empty pixel span")

  // a result cannot appear without an earlier accepted transaction
  `BMPD_ASSERT(a_latency, clk, rst, $rose(out_valid) |-> $past(in_seen, 2), "orphan result")

  // a waiting result stays until taken
  `BMPD_ASSERT(a_out_hold, clk, rst, out_wait |=> out_valid, "result dropped while stalled")

  `BMPD_ASSERT_ALWAYS(a_reset_clear, clk, $past(rst) |-> !out_valid, "result valid after reset")

endmodule

bind bmp_pixel_stream_decoder_core bmpd_checker u_bmpd_checker (.*);
